// File: src/sem_pkg.sv
// Shared types and constants of the Sobel edge magnitude block.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none
package sem_pkg;

  localparam int unsigned MAX_WIDTH_DEF = 2048;
  localparam int unsigned HEIGHT_LIMIT  = 4096;
  localparam int unsigned CFG_W         = 13;
  localparam int unsigned WIDTH_REG_W   = 12;
  localparam int unsigned HEIGHT_REG_W  = 13;
  localparam int unsigned ROW_W         = 13;
  localparam int unsigned CFG_IDX_W     = 1;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 12'd640;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd480;

  localparam logic FUNC_DRAIN = 1'b1;
  localparam logic [7:0] MAG_CLAMP = 8'd255;
  // Largest sum of squares that still rounds to a magnitude of 255.
  localparam logic [21:0] SUM_CLAMP = 22'd65280;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic load;
    logic conv;
    logic square;
    logic root_step;
    logic emit;
  } sem_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic skip;
    logic have;
    logic root_done;
    logic out_free;
  } sem_stat_t;

endpackage
`default_nettype wire

// File: src/sem_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none
module sem_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 2048
) (
  input  wire                     clk_i,
  input  wire                     we_i,
  input  wire [$clog2(DEPTH)-1:0] waddr_i,
  input  wire [WIDTH-1:0]         wdata_i,
  input  wire                     re_i,
  input  wire [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]        rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end
endmodule
`default_nettype wire

// File: src/sem_ctrl.sv
// Controller state machine of the Sobel edge magnitude block.
// Depends on sem_pkg for the command and status structs.
`default_nettype none
module sem_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  sem_pkg::sem_stat_t   stat_i,
  output sem_pkg::sem_cmd_t    cmd_o
);
  import sem_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_LOAD   = 3'd1;
  localparam logic [2:0] ST_CONV   = 3'd2;
  localparam logic [2:0] ST_SQUARE = 3'd3;
  localparam logic [2:0] ST_ROOT   = 3'd4;
  localparam logic [2:0] ST_FIN    = 3'd5;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (!stat_i.skip) begin
            state_d = ST_LOAD;
          end
        end
      end
      ST_LOAD: begin
        cmd_o.load = 1'b1;
        state_d = stat_i.have ? ST_CONV : ST_IDLE;
      end
      ST_CONV: begin
        cmd_o.conv = 1'b1;
        state_d = ST_SQUARE;
      end
      ST_SQUARE: begin
        cmd_o.square = 1'b1;
        state_d = ST_ROOT;
      end
      ST_ROOT: begin
        cmd_o.root_step = 1'b1;
        if (stat_i.root_done) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end
endmodule
`default_nettype wire

// File: src/sem_datapath.sv
// Datapath of the Sobel edge magnitude block: configuration, counters,
// line stores, window, gradients, square root and output register.
// Depends on sem_pkg and sem_ram.
`default_nettype none
module sem_datapath #(
  parameter int unsigned MAX_WIDTH = sem_pkg::MAX_WIDTH_DEF
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 cfg_we_i,
  input  wire [sem_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  wire [sem_pkg::CFG_W-1:0]            cfg_data_i,
  input  wire                                 func_i,
  input  sem_pkg::pixel_t                     pixel_i,
  input  sem_pkg::sem_cmd_t                   cmd_i,
  output sem_pkg::sem_stat_t                  stat_o,
  output logic                                out_valid_o,
  input  wire                                 out_ready_i,
  output sem_pkg::pixel_t                     out_edge_o,
  output logic                                out_last_o
);
  import sem_pkg::*;

  localparam int unsigned AW  = $clog2(MAX_WIDTH);
  localparam int unsigned WW  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned EXT = 14;

  logic [WIDTH_REG_W-1:0]  width_q;
  logic [HEIGHT_REG_W-1:0] height_q;
  logic [WW-1:0]           eff_w;
  logic [ROW_W-1:0]        eff_h;
  logic [EXT-1:0]          width_ext;

  logic [AW-1:0]    col_q;
  logic [ROW_W-1:0] row_q;
  logic [23:0]      win_q [3][3];
  pixel_t           pix_q;
  logic             restart;

  logic [23:0] up_rd, mid_rd, up_g, mid_g;
  logic        pixels_due, wrap, norm;
  logic [ROW_W-1:0] out_row;
  logic [WW-1:0]    col_inc;

  logic mcol0_q, mcol2_q, mrow0_q, mrow2_q, last_q;

  logic signed [11:0] gx_q [3];
  logic signed [11:0] gy_q [3];
  logic [21:0]        s_q [3];
  logic [2:0]         clamp_q;
  logic [7:0]         root_q [3];
  logic [2:0]         bit_q;

  logic   out_valid_q;
  pixel_t edge_q;
  logic   edge_last_q;

  // Effective frame size: zero acts as one, oversize saturates.
  always_comb begin
    width_ext = {{(EXT-WIDTH_REG_W){1'b0}}, width_q};
    if (width_q == '0) begin
      eff_w = WW'(1);
    end else if (width_ext > EXT'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = width_ext[WW-1:0];
    end
    if (height_q == '0) begin
      eff_h = ROW_W'(1);
    end else if (height_q > ROW_W'(HEIGHT_LIMIT)) begin
      eff_h = ROW_W'(HEIGHT_LIMIT);
    end else begin
      eff_h = height_q;
    end
  end

  assign pixels_due  = row_q < eff_h;
  assign restart     = cfg_we_i || (cmd_i.emit && last_q);
  assign stat_o.skip = pixels_due && (func_i == FUNC_DRAIN);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FRAME_WIDTH:  width_q  <= cfg_data_i[WIDTH_REG_W-1:0];
        REG_FRAME_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Line stores: the middle store holds the previous row, the upper one the row
  // before it. Both are read at the column when the word is taken.
  sem_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_ram_upper (
    .clk_i  (clk_i),
    .we_i   (cmd_i.load),
    .waddr_i(col_q),
    .wdata_i(mid_g),
    .re_i   (cmd_i.accept),
    .raddr_i(col_q),
    .rdata_o(up_rd)
  );

  sem_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_ram_middle (
    .clk_i  (clk_i),
    .we_i   (cmd_i.load),
    .waddr_i(col_q),
    .wdata_i(pix_q),
    .re_i   (cmd_i.accept),
    .raddr_i(col_q),
    .rdata_o(mid_rd)
  );

  assign up_g  = (row_q >= ROW_W'(2)) ? up_rd : '0;
  assign mid_g = (row_q != '0) ? mid_rd : '0;

  // A row wrap finishes the last column two rows up; otherwise the pixel left
  // of the one above the new pixel is finished.
  assign wrap    = (col_q == '0) && (row_q >= ROW_W'(2));
  assign norm    = (col_q != '0) && (row_q != '0);
  assign out_row = wrap ? row_q - ROW_W'(2) : row_q - ROW_W'(1);
  assign col_inc = WW'(col_q) + WW'(1);
  assign stat_o.have = wrap || norm;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      pix_q <= pixels_due ? pixel_i : '0;
    end
    if (cmd_i.load) begin
      mcol0_q <= wrap ? (eff_w == WW'(1)) : (col_q == AW'(1));
      mcol2_q <= wrap;
      mrow0_q <= out_row == '0;
      mrow2_q <= out_row == eff_h - ROW_W'(1);
      last_q  <= wrap && (out_row == eff_h - ROW_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_q[r][c] <= '0;
        end
      end
    end else if (restart) begin
      col_q <= '0;
      row_q <= '0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_q[r][c] <= '0;
        end
      end
    end else if (cmd_i.load) begin
      if (col_inc >= eff_w) begin
        col_q <= '0;
        row_q <= row_q + ROW_W'(1);
      end else begin
        col_q <= col_inc[AW-1:0];
      end
      for (int r = 0; r < 3; r++) begin
        win_q[r][0] <= win_q[r][1];
        win_q[r][1] <= win_q[r][2];
      end
      win_q[0][2] <= up_g;
      win_q[1][2] <= mid_g;
      win_q[2][2] <= pix_q;
    end
  end

  // Gradients per channel over the masked window.
  logic signed [11:0] v [3][3][3];
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          if ((c == 0 && mcol0_q) || (c == 2 && mcol2_q) ||
              (r == 0 && mrow0_q) || (r == 2 && mrow2_q)) begin
            v[ch][r][c] = '0;
          end else begin
            v[ch][r][c] = {4'd0, win_q[r][c][8*ch +: 8]};
          end
        end
      end
    end
  end

  logic signed [23:0] px [3];
  logic signed [23:0] py [3];
  logic [7:0]  trial [3];
  logic [15:0] trial_sq [3];
  logic [16:0] q_mid [3];
  logic [7:0]  mag [3];

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      px[ch]       = gx_q[ch] * gx_q[ch];
      py[ch]       = gy_q[ch] * gy_q[ch];
      trial[ch]    = root_q[ch] | 8'(8'd1 << bit_q);
      trial_sq[ch] = trial[ch] * trial[ch];
      q_mid[ch]    = 17'(root_q[ch] * root_q[ch]) + 17'(root_q[ch]);
      if (clamp_q[ch]) begin
        mag[ch] = MAG_CLAMP;
      end else if (s_q[ch] > 22'(q_mid[ch])) begin
        mag[ch] = root_q[ch] + 8'd1;
      end else begin
        mag[ch] = root_q[ch];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int ch = 0; ch < 3; ch++) begin
      if (cmd_i.conv) begin
        gx_q[ch] <= (v[ch][0][2] + (v[ch][1][2] <<< 1) + v[ch][2][2])
                  - (v[ch][0][0] + (v[ch][1][0] <<< 1) + v[ch][2][0]);
        gy_q[ch] <= (v[ch][2][0] + (v[ch][2][1] <<< 1) + v[ch][2][2])
                  - (v[ch][0][0] + (v[ch][0][1] <<< 1) + v[ch][0][2]);
      end
      if (cmd_i.square) begin
        s_q[ch]     <= 22'(px[ch]) + 22'(py[ch]);
        clamp_q[ch] <= (22'(px[ch]) + 22'(py[ch])) > SUM_CLAMP;
        root_q[ch]  <= '0;
      end else if (cmd_i.root_step && (22'(trial_sq[ch]) <= s_q[ch])) begin
        root_q[ch] <= trial[ch];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q <= '0;
    end else if (cmd_i.square) begin
      bit_q <= 3'd7;
    end else if (cmd_i.root_step) begin
      bit_q <= bit_q - 3'd1;
    end
  end

  assign stat_o.root_done = bit_q == '0;
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      edge_q.blue  <= mag[0];
      edge_q.green <= mag[1];
      edge_q.red   <= mag[2];
      edge_last_q  <= last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_edge_o  = edge_q;
  assign out_last_o  = edge_last_q;
endmodule
`default_nettype wire

// File: src/sobel_edge_magnitude_rgb.sv
// Top level of the RGB Sobel edge magnitude block.
// Depends on sem_pkg, sem_ctrl, sem_datapath and sem_ram.
`default_nettype none
// Pixels enter in raster order on the slave stream, one word each; tuser set
// marks a drain word that carries no pixel. Each result is the per-channel
// Sobel magnitude round(sqrt(gx^2 + gy^2)), clamped to 255, with neighbors
// outside the frame taken as zero. Results trail the input by one row plus
// one pixel, so after the last pixel the source sends width + 1 further words
// (drain words or pixels, which are then ignored) to flush the frame; tlast
// marks the frame's final result, after which the next pixel opens a new
// frame. A drain word sent while pixels are still due is dropped. Writing
// either register restarts the frame; write only while the block is idle.
// A word that yields a result occupies the block through its take, line
// store access, gradients, squares, eight square-root steps and output; the
// eight-step square root is the longest part. A word without a result is
// taken and accesses the line stores; a dropped drain word is only taken.
// The output register lets the next word be taken while a result waits.
module sobel_edge_magnitude_rgb #(
  parameter int unsigned MAX_WIDTH = sem_pkg::MAX_WIDTH_DEF
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_we_i,
  input  wire [sem_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire [sem_pkg::CFG_W-1:0]     cfg_data_i,
  input  wire                          s_axis_tvalid,
  output logic                         s_axis_tready,
  // tdata: pixel_red [7:0], pixel_green [15:8], pixel_blue [23:16]
  input  wire [23:0]                   s_axis_tdata,
  // tuser: func (1 = drain word)
  input  wire                          s_axis_tuser,
  output logic                         m_axis_tvalid,
  input  wire                          m_axis_tready,
  // tdata: edge_red [7:0], edge_green [15:8], edge_blue [23:16]
  output logic [23:0]                  m_axis_tdata,
  // tlast: frame_last
  output logic                         m_axis_tlast
);
  import sem_pkg::*;

  sem_cmd_t  cmd;
  sem_stat_t stat;
  pixel_t    pix_in, edge_out;

  assign pix_in.red   = s_axis_tdata[7:0];
  assign pix_in.green = s_axis_tdata[15:8];
  assign pix_in.blue  = s_axis_tdata[23:16];

  sem_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  sem_datapath #(.MAX_WIDTH(MAX_WIDTH)) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .func_i     (s_axis_tuser),
    .pixel_i    (pix_in),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_edge_o (edge_out),
    .out_last_o (m_axis_tlast)
  );

  assign m_axis_tdata = {edge_out.blue, edge_out.green, edge_out.red};

  // The controller issues at most one command per cycle.
  a_cmd_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.accept, cmd.load, cmd.conv, cmd.square, cmd.root_step, cmd.emit}))
    else $error("controller issued overlapping commands");

  // A result is only loaded when the output register can take it.
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> stat.out_free)
    else $error("result loaded over a waiting result");

  // Line store data is consumed the cycle after the read was issued.
  a_load_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |-> $past(cmd.accept))
    else $error("line store data used without a read");
endmodule
`default_nettype wire
